@@ hw/rtl/best_fit_heap_allocator_core_assert.svh @@
// Assertion macros used by the allocator core
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define BFH_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define BFH_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/bfh_pkg.sv @@
package bfh_pkg;
  localparam int unsigned POOL_BYTES_DEF = 1048576;
  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam int unsigned HDR_BYTES = 32;
  localparam int unsigned MIN_SPLIT = 64;
  localparam int unsigned OFF_W = 20;
  localparam int unsigned SIZE_W = 24;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_FIT = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_A_RD, S_A_EV, S_A_DEC, S_A_SP_RD, S_A_SP_EV, S_A_WR,
    S_F_RD, S_F_EV, S_F_NX_RD, S_F_NX_EV, S_F_P_RD, S_F_P_EV,
    S_F_PH_RD, S_F_PH_EV, S_DONE
  } state_t;
endpackage

@@ hw/rtl/best_fit_heap_allocator_core.sv @@
// Channel  | Ports                                         | Direction
// request  | start, busy, mode, request_size, release_offset | in, busy out
// result   | done, granted_offset, status                  | out
// One request walks the block table, reading each visited entry and then
// evaluating it. A split adds a scan for a spare entry, and a free adds a
// second walk for the predecessor.
// Reset is synchronous; entry 0 is then the whole pool, other entries invalid.
// busy stays high until done; done lasts one cycle and cannot be stalled.
module best_fit_heap_allocator_core
  import bfh_pkg::*;
#(
  parameter longint unsigned POOL_BYTES = POOL_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [SIZE_W-1:0]     request_size,
  input  logic [OFF_W-1:0]      release_offset,
  output logic                  done,
  output logic [OFF_W-1:0]      granted_offset,
  output logic [1:0]            status
);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned AW = $clog2(POOL_BYTES) + 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [AW-1:0] HDR = AW'(HDR_BYTES);

  // block table memory: start, payload, in_use, link; valid in flip-flops
  logic [AW-1:0] mem_start [MAX_BLOCKS];
  logic [AW-1:0] mem_pay [MAX_BLOCKS];
  logic          mem_use [MAX_BLOCKS];
  logic [IW-1:0] mem_link [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid;

  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] r_start, r_pay;
  logic          r_use;
  logic [IW-1:0] r_link;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [AW-1:0] wr_start, wr_pay;
  logic          wr_use;
  logic [IW-1:0] wr_link;
  logic          clr_en;
  logic [IW-1:0] clr_addr;
  logic          set_en;
  logic [IW-1:0] set_addr;

  state_t state, state_next;
  logic [IW-1:0] cur, best, spare, hit, nx, prv;
  logic [AW-1:0] need, best_pay, best_start, h_pay, h_start;
  logic [IW-1:0] best_link, h_link;
  logic          found;
  logic [CW-1:0] steps;
  logic [OFF_W-1:0] rel;

  logic [IW-1:0] cur_next, best_next, spare_next, hit_next, nx_next, prv_next;
  logic [AW-1:0] need_next, best_pay_next, best_start_next, h_pay_next, h_start_next;
  logic [IW-1:0] best_link_next, h_link_next;
  logic          found_next;
  logic [CW-1:0] steps_next;
  logic [OFF_W-1:0] res_off, res_off_next;
  logic [1:0]    res_st, res_st_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_pay[wr_addr] <= wr_pay;
      mem_use[wr_addr] <= wr_use;
      mem_link[wr_addr] <= wr_link;
    end
    if (rd_en) begin
      r_start <= mem_start[rd_addr];
      r_pay <= mem_pay[rd_addr];
      r_use <= mem_use[rd_addr];
      r_link <= mem_link[rd_addr];
    end
  end

  // entry 0 is written into the table after reset by the init write below
  logic init_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= MAX_BLOCKS'(1);
      init_done <= 1'b0;
    end else begin
      init_done <= 1'b1;
      if (clr_en) valid[clr_addr] <= 1'b0;
      if (set_en) valid[set_addr] <= 1'b1;
    end
  end

  logic rv;
  always_ff @(posedge clk) if (rd_en) rv <= valid[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    cur <= cur_next; best <= best_next; spare <= spare_next; hit <= hit_next;
    nx <= nx_next; prv <= prv_next; need <= need_next; best_pay <= best_pay_next;
    best_start <= best_start_next; h_pay <= h_pay_next; h_start <= h_start_next;
    best_link <= best_link_next; h_link <= h_link_next; found <= found_next;
    steps <= steps_next; res_off <= res_off_next; res_st <= res_st_next;
    if (state == S_IDLE && start && init_done) begin
      rel <= release_offset;
    end
  end

  // shared adder
  logic [AW-1:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  logic [SIZE_W:0] rsz, rnd;
  assign rsz = {1'b0, request_size} + (SIZE_W+1)'(15);
  assign rnd = {rsz[SIZE_W:4], 4'b0};

  always_comb begin
    state_next = state;
    cur_next = cur; best_next = best; spare_next = spare; hit_next = hit;
    nx_next = nx; prv_next = prv; need_next = need; best_pay_next = best_pay;
    best_start_next = best_start; h_pay_next = h_pay; h_start_next = h_start;
    best_link_next = best_link; h_link_next = h_link; found_next = found;
    steps_next = steps; res_off_next = res_off; res_st_next = res_st;
    rd_en = 1'b0; rd_addr = cur;
    wr_en = 1'b0; wr_addr = '0; wr_start = '0; wr_pay = '0; wr_use = 1'b0;
    wr_link = '0;
    clr_en = 1'b0; clr_addr = '0; set_en = 1'b0; set_addr = '0;
    add_a = '0; add_b = '0;
    if (!init_done) begin
      wr_en = 1'b1; wr_addr = '0; wr_pay = AW'(POOL_BYTES - HDR_BYTES);
    end
    unique case (state)
      S_IDLE: begin
        if (start && init_done) begin
          cur_next = '0; steps_next = '0; found_next = 1'b0; best_next = '0;
          res_off_next = '0;
          if (!mode) begin
            need_next = AW'(rnd);
            if (request_size == '0 ||
                {{(64-SIZE_W){1'b0}}, request_size} > POOL_BYTES - HDR_BYTES ||
                64'(rnd) + 64'(HDR_BYTES) > 64'(POOL_BYTES)) begin
              res_st_next = ST_BAD_SIZE; state_next = S_DONE;
            end else begin
              state_next = S_A_RD;
            end
          end else if (release_offset == '0) begin
            res_st_next = ST_IGNORED; state_next = S_DONE;
          end else begin
            state_next = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        rd_en = 1'b1; rd_addr = cur; state_next = S_A_EV;
      end
      S_A_EV: begin
        if (rv && !r_use && r_pay >= need && (!found || r_pay < best_pay)) begin
          found_next = 1'b1; best_next = cur; best_pay_next = r_pay;
          best_start_next = r_start; best_link_next = r_link;
        end
        cur_next = r_link; steps_next = steps + CW'(1);
        if (r_link == '0 || steps + CW'(1) == CW'(MAX_BLOCKS))
          state_next = S_A_DEC;
        else
          state_next = S_A_RD;
      end
      S_A_DEC: begin
        if (!found) begin
          res_st_next = ST_NO_FIT; state_next = S_DONE;
        end else begin
          add_a = need; add_b = AW'(HDR_BYTES + MIN_SPLIT);
          spare_next = IW'(1);
          res_st_next = ST_OK;
          if ({1'b0, best_pay} >= {1'b0, need} + (AW+1)'(HDR_BYTES + MIN_SPLIT))
            state_next = S_A_SP_RD;
          else begin
            spare_next = '0; state_next = S_A_WR;
          end
        end
      end
      S_A_SP_RD: begin
        // scan valid bits one per cycle for the lowest free entry
        if (!valid[spare]) state_next = S_A_SP_EV;
        else if (spare == IW'(MAX_BLOCKS - 1)) begin
          spare_next = '0; state_next = S_A_WR;
        end else spare_next = spare + IW'(1);
      end
      S_A_SP_EV: begin
        add_a = best_start; add_b = HDR + need;
        wr_en = 1'b1; wr_addr = spare; wr_start = add_y;
        wr_pay = best_pay - need - HDR; wr_use = 1'b0; wr_link = best_link;
        set_en = 1'b1; set_addr = spare;
        best_link_next = spare; best_pay_next = need;
        state_next = S_A_WR;
      end
      S_A_WR: begin
        add_a = best_start; add_b = HDR;
        wr_en = 1'b1; wr_addr = best; wr_start = best_start; wr_pay = best_pay;
        wr_use = 1'b1; wr_link = best_link;
        res_off_next = add_y[OFF_W-1:0];
        state_next = S_DONE;
      end
      S_F_RD: begin
        rd_en = 1'b1; rd_addr = cur; state_next = S_F_EV;
      end
      S_F_EV: begin
        add_a = r_start; add_b = HDR;
        if (rv && r_use && add_y[OFF_W-1:0] == rel) begin
          hit_next = cur; h_start_next = r_start; h_pay_next = r_pay;
          h_link_next = r_link; nx_next = r_link; state_next = S_F_NX_RD;
        end else begin
          cur_next = r_link; steps_next = steps + CW'(1);
          if (r_link == '0 || steps + CW'(1) == CW'(MAX_BLOCKS)) begin
            res_st_next = ST_IGNORED; state_next = S_DONE;
          end else state_next = S_F_RD;
        end
      end
      S_F_NX_RD: begin
        rd_en = 1'b1; rd_addr = nx; state_next = S_F_NX_EV;
      end
      S_F_NX_EV: begin
        add_a = h_pay; add_b = HDR + r_pay;
        if (nx != '0 && rv && !r_use) begin
          h_pay_next = add_y; h_link_next = r_link;
          clr_en = 1'b1; clr_addr = nx;
          wr_en = 1'b1; wr_addr = nx;
        end
        res_st_next = ST_OK;
        prv_next = '0; steps_next = '0;
        state_next = (hit == '0) ? S_F_PH_EV : S_F_P_RD;
      end
      S_F_P_RD: begin
        rd_en = 1'b1; rd_addr = prv; state_next = S_F_P_EV;
      end
      S_F_P_EV: begin
        steps_next = steps + CW'(1);
        if (r_link == hit) begin
          state_next = S_F_PH_RD;
        end else if (r_link == '0 || steps + CW'(1) == CW'(MAX_BLOCKS)) begin
          state_next = S_F_PH_EV; prv_next = hit;
        end else begin
          prv_next = r_link; state_next = S_F_P_RD;
        end
      end
      S_F_PH_RD: begin
        rd_en = 1'b1; rd_addr = prv; state_next = S_F_PH_EV;
        if (!(rv && !r_use)) prv_next = hit;
      end
      S_F_PH_EV: begin
        // merge into predecessor when one was found free, else rewrite hit
        if (hit != '0 && prv != hit) begin
          add_a = r_pay; add_b = HDR + h_pay;
          wr_en = 1'b1; wr_addr = prv; wr_start = r_start; wr_pay = add_y;
          wr_use = 1'b0; wr_link = h_link;
          clr_en = 1'b1; clr_addr = hit;
        end else begin
          wr_en = 1'b1; wr_addr = hit; wr_start = h_start; wr_pay = h_pay;
          wr_use = 1'b0; wr_link = h_link;
        end
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE) || !init_done;
  assign done = (state == S_DONE);
  assign granted_offset = res_off;
  assign status = res_st;

  `include "best_fit_heap_allocator_core_assert.svh"
  `BFH_ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  `BFH_ASSERT_NXT(a_done_once, clk, rst, done, !done)
  `BFH_ASSERT_IMP(a_fail_zero, clk, rst, done && status != ST_OK, granted_offset == '0)
endmodule
